// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property sampled on the rising clock, muted while reset is low.
`define SFG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SFG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SFG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sfg_pkg.sv -----
`default_nettype none

package sfg_pkg;

	localparam int MAX_SIZE_DEF = 2048;

	localparam int SIZE_W  = 12;
	localparam int RAD_W   = 16;
	localparam int EXP_W   = 12;
	localparam int COLOR_W = 8;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 10;
	localparam int COORD_W = 11;
	localparam int SUMSQ_W = 22;
	localparam int DIST_W  = 27;
	localparam int Q16_W   = 17;
	localparam int Q30_W   = 31;
	localparam int ROOT_ROUNDS = 8;

	localparam logic [Q16_W-1:0] ONE16 = 17'h10000;
	localparam logic [Q30_W-1:0] ONE30 = 31'h4000_0000;

	// sine series coefficients, Q1.30
	localparam logic [Q30_W-1:0] CA1 = 31'd1686629713;
	localparam logic [Q30_W-1:0] CA3 = 31'd693598669;
	localparam logic [Q30_W-1:0] CA5 = 31'd85569306;
	localparam logic [Q30_W-1:0] CA7 = 31'd5026995;
	localparam logic [Q30_W-1:0] CA9 = 31'd172272;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TEXTURE_SIZE = 3'd0;
	localparam logic [IDX_W-1:0] REG_RADIUS       = 3'd1;
	localparam logic [IDX_W-1:0] REG_EXPONENT     = 3'd2;
	localparam logic [IDX_W-1:0] REG_COLOR_RED    = 3'd3;
	localparam logic [IDX_W-1:0] REG_COLOR_GREEN  = 3'd4;
	localparam logic [IDX_W-1:0] REG_COLOR_BLUE   = 3'd5;

	// intensity modes settled once the distance is known
	localparam logic [1:0] MODE_CALC = 2'd0;
	localparam logic [1:0] MODE_ONE  = 2'd1;
	localparam logic [1:0] MODE_ZERO = 2'd2;

	localparam logic [2:0] BEAT_LAST = 3'd7;

	typedef struct packed {
		logic [1:0]      mode;
		logic [IN_W-1:0] col;
		logic [IN_W-1:0] row;
	} side_t;

	typedef struct packed {
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
		logic [COORD_W-1:0] mx;
		logic [COORD_W-1:0] my;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} texel_item_t;

	// one Horner step: ca - u2 * p / 2^16
	function automatic logic [Q30_W-1:0] horner_step(
		input logic [Q16_W-1:0] u2,
		input logic [Q30_W-1:0] p,
		input logic [Q30_W-1:0] ca
	);
		logic [Q16_W+Q30_W-1:0] prod;
		prod = u2 * p;
		return ca - prod[Q30_W+15:16];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sfg_isqrt.sv -----
`default_nettype none

module sfg_isqrt #(
	parameter int N = 27
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  logic [2*N-1:0]    in_x,
	input  sfg_pkg::side_t    in_side,
	output logic              out_v,
	output logic [N-1:0]      out_root,
	output sfg_pkg::side_t    out_side
);
	import sfg_pkg::*;

	localparam int RW = N + 3;

	logic [N-1:0]   v_s;
	logic [2*N-1:0] x_s    [N];
	logic [RW-1:0]  rem_s  [N];
	logic [N-1:0]   root_s [N];
	side_t          side_s [N];

	logic [N-1:0]   pv;
	logic [2*N-1:0] px     [N];
	logic [RW-1:0]  prem   [N];
	logic [N-1:0]   proot  [N];
	side_t          pside  [N];
	logic [RW-1:0]  cand   [N];
	logic [RW-1:0]  trial  [N];

	// one result bit per stage, two radicand bits shifted in each time
	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				pv[k]    = in_v;
				px[k]    = in_x;
				prem[k]  = '0;
				proot[k] = '0;
				pside[k] = in_side;
			end else begin
				pv[k]    = v_s[k-1];
				px[k]    = x_s[k-1];
				prem[k]  = rem_s[k-1];
				proot[k] = root_s[k-1];
				pside[k] = side_s[k-1];
			end
			cand[k]  = {prem[k][RW-3:0], px[k][2*N-1 -: 2]};
			trial[k] = RW'({proot[k], 2'b01});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < N; k++) begin
				x_s[k]    <= {px[k][2*N-3:0], 2'b00};
				side_s[k] <= pside[k];
				if (cand[k] >= trial[k]) begin
					rem_s[k]  <= cand[k] - trial[k];
					root_s[k] <= {proot[k][N-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cand[k];
					root_s[k] <= {proot[k][N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_v    = v_s[N-1];
	assign out_root = root_s[N-1];
	assign out_side = side_s[N-1];

endmodule

`default_nettype wire

// ----- rtl/sfg_div.sv -----
`default_nettype none

module sfg_div #(
	parameter int DEN_W = 10,
	parameter int Q_W   = 27
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  logic [DEN_W-1:0]  in_rem,
	input  logic [Q_W-1:0]    in_bits,
	input  logic [DEN_W-1:0]  den,
	input  sfg_pkg::side_t    in_side,
	output logic              out_v,
	output logic [Q_W-1:0]    out_q,
	output sfg_pkg::side_t    out_side
);
	import sfg_pkg::*;

	logic [Q_W-1:0]   v_s;
	logic [DEN_W-1:0] rem_s  [Q_W];
	logic [Q_W-1:0]   qb_s   [Q_W];
	side_t            side_s [Q_W];

	logic [Q_W-1:0]   pv;
	logic [DEN_W-1:0] prem   [Q_W];
	logic [Q_W-1:0]   pqb    [Q_W];
	side_t            pside  [Q_W];
	logic [DEN_W:0]   cand   [Q_W];
	logic [Q_W-1:0]   ge;

	// restoring division; dividend bits leave the top as quotient bits enter below
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				pv[k]    = in_v;
				prem[k]  = in_rem;
				pqb[k]   = in_bits;
				pside[k] = in_side;
			end else begin
				pv[k]    = v_s[k-1];
				prem[k]  = rem_s[k-1];
				pqb[k]   = qb_s[k-1];
				pside[k] = side_s[k-1];
			end
			cand[k] = {prem[k], pqb[k][Q_W-1]};
			ge[k]   = cand[k] >= {1'b0, den};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < Q_W; k++) begin
				side_s[k] <= pside[k];
				qb_s[k]   <= {pqb[k][Q_W-2:0], ge[k]};
				if (ge[k]) begin
					rem_s[k] <= DEN_W'(cand[k] - {1'b0, den});
				end else begin
					rem_s[k] <= cand[k][DEN_W-1:0];
				end
			end
		end
	end

	assign out_v    = v_s[Q_W-1];
	assign out_q    = qb_s[Q_W-1];
	assign out_side = side_s[Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/sfg_cos.sv -----
`default_nettype none

module sfg_cos (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_v,
	input  logic [15:0]               in_t,
	input  sfg_pkg::side_t            in_side,
	output logic                      out_v,
	output logic [sfg_pkg::Q16_W-1:0] out_c,
	output sfg_pkg::side_t            out_side
);
	import sfg_pkg::*;

	logic [5:0]         v_s;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [Q16_W-1:0]   u_s1, u_s2, u_s3, u_s4, u_s5;
	logic [Q16_W-1:0]   u2_s1, u2_s2, u2_s3, u2_s4;
	logic [Q30_W-1:0]   p_s2, p_s3, p_s4, p_s5;
	logic [Q16_W-1:0]   c_s6;

	logic [Q16_W-1:0]       u_in;
	logic [2*Q16_W-1:0]     usq;
	logic [Q16_W+Q30_W-1:0] fin;
	logic [17:0]            craw;

	assign u_in = ONE16 - {1'b0, in_t};
	assign usq  = u_in * u_in;
	assign fin  = u_s5 * p_s5;
	assign craw = fin[Q16_W+Q30_W-1:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[4:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1    <= u_in;
			u2_s1   <= usq[Q16_W+15:16];
			side_s1 <= in_side;

			u_s2    <= u_s1;
			u2_s2   <= u2_s1;
			p_s2    <= horner_step(u2_s1, CA9, CA7);
			side_s2 <= side_s1;

			u_s3    <= u_s2;
			u2_s3   <= u2_s2;
			p_s3    <= horner_step(u2_s2, p_s2, CA5);
			side_s3 <= side_s2;

			u_s4    <= u_s3;
			u2_s4   <= u2_s3;
			p_s4    <= horner_step(u2_s3, p_s3, CA3);
			side_s4 <= side_s3;

			u_s5    <= u_s4;
			p_s5    <= horner_step(u2_s4, p_s4, CA1);
			side_s5 <= side_s4;

			// clamp to one
			c_s6    <= (craw > {1'b0, ONE16}) ? ONE16 : craw[Q16_W-1:0];
			side_s6 <= side_s5;
		end
	end

	assign out_v    = v_s[5];
	assign out_c    = c_s6;
	assign out_side = side_s6;

endmodule

`default_nettype wire

// ----- rtl/sfg_pow.sv -----
`default_nettype none

module sfg_pow (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_v,
	input  logic [sfg_pkg::Q16_W-1:0] in_c,
	input  sfg_pkg::side_t            in_side,
	input  logic [sfg_pkg::EXP_W-1:0] exponent,
	output logic                      out_v,
	output logic [sfg_pkg::Q16_W-1:0] out_i,
	output sfg_pkg::side_t            out_side
);
	import sfg_pkg::*;

	logic [ROOT_ROUNDS:0] rv;
	logic [Q30_W-1:0]     rr [ROOT_ROUNDS+1];
	side_t                rs [ROOT_ROUNDS+1];

	assign rv[0] = in_v;
	assign rr[0] = {in_c, 14'b0};
	assign rs[0] = in_side;

	// eight chained square roots give the 256th root of c
	for (genvar g = 0; g < ROOT_ROUNDS; g++) begin : g_root
		sfg_isqrt #(
			.N(Q30_W)
		) u_root (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_v     (rv[g]),
			.in_x     ({1'b0, rr[g], 30'b0}),
			.in_side  (rs[g]),
			.out_v    (rv[g+1]),
			.out_root (rr[g+1]),
			.out_side (rs[g+1])
		);
	end

	logic [EXP_W-1:0] v_s;
	logic [Q30_W-1:0] res_s  [EXP_W];
	logic [Q30_W-1:0] base_s [EXP_W];
	side_t            side_s [EXP_W];

	logic [EXP_W-1:0]   pv;
	logic [Q30_W-1:0]   pres  [EXP_W];
	logic [Q30_W-1:0]   pbase [EXP_W];
	side_t              pside [EXP_W];
	logic [2*Q30_W-1:0] pm    [EXP_W];
	logic [2*Q30_W-1:0] ps    [EXP_W];

	// square and multiply, one exponent bit per stage from the LSB
	always_comb begin
		for (int k = 0; k < EXP_W; k++) begin
			if (k == 0) begin
				pv[k]    = rv[ROOT_ROUNDS];
				pres[k]  = ONE30;
				pbase[k] = rr[ROOT_ROUNDS];
				pside[k] = rs[ROOT_ROUNDS];
			end else begin
				pv[k]    = v_s[k-1];
				pres[k]  = res_s[k-1];
				pbase[k] = base_s[k-1];
				pside[k] = side_s[k-1];
			end
			pm[k] = pres[k] * pbase[k];
			ps[k] = pbase[k] * pbase[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < EXP_W; k++) begin
				side_s[k] <= pside[k];
				base_s[k] <= ps[k][60:30];
				res_s[k]  <= exponent[k] ? pm[k][60:30] : pres[k];
			end
		end
	end

	assign out_v    = v_s[EXP_W-1];
	assign out_i    = res_s[EXP_W-1][30:14];
	assign out_side = side_s[EXP_W-1];

endmodule

`default_nettype wire

// ----- rtl/sfg_emit.sv -----
`default_nettype none

module sfg_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_v,
	input  sfg_pkg::texel_item_t        in_item,
	output logic                        take,
	output logic                        valid,
	output logic [sfg_pkg::COORD_W-1:0] texel_x,
	output logic [sfg_pkg::COORD_W-1:0] texel_y,
	output logic [sfg_pkg::COLOR_W-1:0] red,
	output logic [sfg_pkg::COLOR_W-1:0] green,
	output logic [sfg_pkg::COLOR_W-1:0] blue,
	output logic                        last
);
	import sfg_pkg::*;

	logic        act_q;
	logic [2:0]  cnt_q;
	texel_item_t item_q;
	logic [COORD_W-1:0] bx, by;

	// load a new sample when idle or on the final beat of the current one
	assign take = in_v && (!act_q || (cnt_q == BEAT_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			if (cnt_q == BEAT_LAST) begin
				act_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= in_item;
		end
	end

	always_comb begin
		case (cnt_q)
			3'd0: begin bx = item_q.tx; by = item_q.ty; end
			3'd1: begin bx = item_q.tx; by = item_q.my; end
			3'd2: begin bx = item_q.mx; by = item_q.ty; end
			3'd3: begin bx = item_q.mx; by = item_q.my; end
			3'd4: begin bx = item_q.ty; by = item_q.tx; end
			3'd5: begin bx = item_q.ty; by = item_q.mx; end
			3'd6: begin bx = item_q.my; by = item_q.tx; end
			3'd7: begin bx = item_q.my; by = item_q.mx; end
			default: begin bx = item_q.tx; by = item_q.ty; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			last  <= 1'b0;
		end else begin
			valid <= act_q;
			last  <= act_q && (cnt_q == BEAT_LAST);
		end
	end

	always_ff @(posedge clk) begin
		texel_x <= bx;
		texel_y <= by;
		red     <= item_q.red;
		green   <= item_q.green;
		blue    <= item_q.blue;
	end

endmodule

`default_nettype wire

// ----- rtl/spot_falloff_texel_gen_top.sv -----
`default_nettype none

// Spotlight falloff texel generator.
// Input: pulse start with an octant sample (col, row); the sample is taken at a
// rising edge where start is high and busy is low. Each sample produces eight
// mirrored texel writes, one beat per cycle on texel_x/texel_y/red/green/blue,
// marked by valid; last flags the eighth beat. Beats cannot be held off.
// Configuration: cfg_we with cfg_index/cfg_data writes one register per edge;
// write only when no sample is in flight.
// Pipeline: a sum-of-squares register, then a chain of pipelined units: distance
// square root (27 stages), divide by the half width (27), a classify register,
// falloff divide (16), cosine series (6), eight 31-stage square roots and
// 12 square-and-multiply stages for the power, then a final register.
// Result channel: loads a sample when idle or on the final beat of the last one;
// busy stalls the whole pipeline while a finished sample waits for its beats.
// Reset: clears every valid bit and loads register defaults (size 256,
// radius one half, exponent one, white color).
module spot_falloff_texel_gen_top #(
	parameter int MAX_SIZE = sfg_pkg::MAX_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [sfg_pkg::IN_W-1:0]    col,
	input  logic [sfg_pkg::IN_W-1:0]    row,
	input  logic                        cfg_we,
	input  logic [sfg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sfg_pkg::CFG_W-1:0]   cfg_data,
	output logic                        valid,
	output logic [sfg_pkg::COORD_W-1:0] texel_x,
	output logic [sfg_pkg::COORD_W-1:0] texel_y,
	output logic [sfg_pkg::COLOR_W-1:0] red,
	output logic [sfg_pkg::COLOR_W-1:0] green,
	output logic [sfg_pkg::COLOR_W-1:0] blue,
	output logic                        last
);
	import sfg_pkg::*;

	// half width bits that the largest allowed size needs
	localparam int H_W = $clog2(MAX_SIZE / 2);

	// configuration registers
	logic [SIZE_W-1:0]  texture_size_q;
	logic [RAD_W-1:0]   radius_q;
	logic [EXP_W-1:0]   exponent_q;
	logic [COLOR_W-1:0] color_red_q, color_green_q, color_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_size_q <= 12'd256;
			radius_q       <= 16'd32768;
			exponent_q     <= 12'd256;
			color_red_q    <= 8'd255;
			color_green_q  <= 8'd255;
			color_blue_q   <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXTURE_SIZE: texture_size_q <= cfg_data[SIZE_W-1:0];
				REG_RADIUS:       radius_q       <= cfg_data[RAD_W-1:0];
				REG_EXPONENT:     exponent_q     <= cfg_data[EXP_W-1:0];
				REG_COLOR_RED:    color_red_q    <= cfg_data[COLOR_W-1:0];
				REG_COLOR_GREEN:  color_green_q  <= cfg_data[COLOR_W-1:0];
				REG_COLOR_BLUE:   color_blue_q   <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the size, then half width = size/2 - 1, zero below four
	logic [SIZE_W-1:0] size_w;
	logic [H_W-1:0]    h_w;

	assign size_w = ({1'b0, texture_size_q} > (SIZE_W+1)'(MAX_SIZE)) ?
		SIZE_W'(MAX_SIZE) : texture_size_q;
	assign h_w = (size_w >= 12'd4) ? H_W'(size_w[SIZE_W-1:1] - 11'd1) : '0;

	// global advance: hold everything while a finished sample waits
	logic        adv;
	logic        take;
	logic        v_sf;

	assign adv  = !v_sf || take;
	assign busy = !adv;

	// stage 1: sum of squares
	logic               v_s1;
	logic [SUMSQ_W-1:0] sumsq_s1;
	side_t              side_s1;
	logic [IN_W:0]      c1, r1;

	assign c1 = {1'b0, col} + 11'd1;
	assign r1 = {1'b0, row} + 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sumsq_s1 <= SUMSQ_W'(c1 * c1) + SUMSQ_W'(r1 * r1);
			side_s1  <= '{mode: MODE_CALC, col: col, row: row};
		end
	end

	// distance root, Q16 scaled
	logic              v_rt;
	logic [DIST_W-1:0] root_rt;
	side_t             side_rt;

	sfg_isqrt #(
		.N(DIST_W)
	) u_dist_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s1),
		.in_x     ({sumsq_s1, 32'b0}),
		.in_side  (side_s1),
		.out_v    (v_rt),
		.out_root (root_rt),
		.out_side (side_rt)
	);

	// normalize by the half width
	logic              v_dq;
	logic [DIST_W-1:0] d_dq;
	side_t             side_dq;

	sfg_div #(
		.DEN_W(H_W),
		.Q_W  (DIST_W)
	) u_dist_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_rt),
		.in_rem   ('0),
		.in_bits  (root_rt),
		.den      (h_w),
		.in_side  (side_rt),
		.out_v    (v_dq),
		.out_q    (d_dq),
		.out_side (side_dq)
	);

	// classify: full brightness inside the radius, dark at or beyond one
	logic        v_sd;
	logic [15:0] n_sd;
	side_t       side_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd <= 1'b0;
		end else if (adv) begin
			v_sd <= v_dq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_sd          <= d_dq[15:0] - radius_q;
			side_sd.col   <= side_dq.col;
			side_sd.row   <= side_dq.row;
			if (d_dq <= DIST_W'(radius_q)) begin
				side_sd.mode <= MODE_ONE;
			end else if (d_dq >= DIST_W'(ONE16)) begin
				side_sd.mode <= MODE_ZERO;
			end else begin
				side_sd.mode <= MODE_CALC;
			end
		end
	end

	// falloff parameter t = (D - r) / (1 - r), Q16
	logic        v_tq;
	logic [15:0] t_tq;
	side_t       side_tq;

	sfg_div #(
		.DEN_W(Q16_W),
		.Q_W  (16)
	) u_fall_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_sd),
		.in_rem   ({1'b0, n_sd}),
		.in_bits  ('0),
		.den      (ONE16 - {1'b0, radius_q}),
		.in_side  (side_sd),
		.out_v    (v_tq),
		.out_q    (t_tq),
		.out_side (side_tq)
	);

	logic             v_cs;
	logic [Q16_W-1:0] c_cs;
	side_t            side_cs;

	sfg_cos u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_tq),
		.in_t     (t_tq),
		.in_side  (side_tq),
		.out_v    (v_cs),
		.out_c    (c_cs),
		.out_side (side_cs)
	);

	logic             v_pw;
	logic [Q16_W-1:0] i_pw;
	side_t            side_pw;

	sfg_pow u_pow (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_cs),
		.in_c     (c_cs),
		.in_side  (side_cs),
		.exponent (exponent_q),
		.out_v    (v_pw),
		.out_i    (i_pw),
		.out_side (side_pw)
	);

	// final stage: pick intensity, scale colors, build mirrored coordinates
	logic [Q16_W-1:0]         inten;
	logic [Q16_W+COLOR_W-1:0] pr, pg, pb;
	logic [COORD_W-1:0]       tx, ty;
	texel_item_t              item_sf;

	always_comb begin
		case (side_pw.mode)
			MODE_ONE:  inten = ONE16;
			MODE_ZERO: inten = '0;
			default:   inten = i_pw;
		endcase
	end

	assign pr = inten * color_red_q;
	assign pg = inten * color_green_q;
	assign pb = inten * color_blue_q;
	assign tx = COORD_W'({1'b0, side_pw.col} + COORD_W'(h_w));
	assign ty = COORD_W'({1'b0, side_pw.row} + COORD_W'(h_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (adv) begin
			v_sf <= v_pw;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_sf.tx    <= tx;
			item_sf.ty    <= ty;
			item_sf.mx    <= COORD_W'(size_w - {1'b0, tx} - 12'd1);
			item_sf.my    <= COORD_W'(size_w - {1'b0, ty} - 12'd1);
			item_sf.red   <= pr[23:16];
			item_sf.green <= pg[23:16];
			item_sf.blue  <= pb[23:16];
		end
	end

	// eight beats per sample on the result ports
	sfg_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_sf),
		.in_item (item_sf),
		.take    (take),
		.valid   (valid),
		.texel_x (texel_x),
		.texel_y (texel_y),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.last    (last)
	);

endmodule

`default_nettype wire

// ----- rtl/sfg_check.sv -----
`default_nettype none

`include "assert_macros.svh"

module sfg_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       valid,
	input wire logic       last,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	// a sample's beats run back to back until the flagged one
	`SFG_ASSERT_NEXT(a_burst_contig, valid && !last, valid, "beat gap inside a sample")

	// one color for all eight writes of a sample
	`SFG_ASSERT_NEXT(a_color_hold, valid && !last,
		$stable(red) && $stable(green) && $stable(blue), "color changed inside a sample")

	// a burst never starts on its final beat
	`SFG_ASSERT_IMP(a_first_not_last, $rose(valid), !last, "burst opened with last")

	`SFG_ASSERT(a_last_valid, !last || valid, "last without valid")

endmodule

bind spot_falloff_texel_gen_top sfg_check u_check (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (valid),
	.last   (last),
	.red    (red),
	.green  (green),
	.blue   (blue)
);

`default_nettype wire

// ----- verif/tb_spot_falloff_texel_gen_top.sv -----
`timescale 1ns / 1ps

module tb_spot_falloff_texel_gen_top;
	import sfg_pkg::*;

	typedef bit [63:0] u64;

	localparam int  SIZE_CAP    = MAX_SIZE_DEF;
	localparam int  DRAIN_WAIT  = 400;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  PHASE_ITEMS = 34;

	// one expected texel write
	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic               lst;
	} texel_write_t;

	// directed sample; colors typed in only where obvious (same value on all channels)
	typedef struct {
		int  c;
		int  rw;
		bit  typed;
		int  shade;
	} sample_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [IN_W-1:0]    col;
	logic [IN_W-1:0]    row;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               valid;
	logic [COORD_W-1:0] texel_x;
	logic [COORD_W-1:0] texel_y;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               last;

	spot_falloff_texel_gen_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.col(col), .row(row),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.valid(valid), .texel_x(texel_x), .texel_y(texel_y),
		.red(red), .green(green), .blue(blue), .last(last)
	);

	// shadow copy of the light settings
	int unsigned tex_size, inner_rad, falloff_exp, light_r, light_g, light_b;

	texel_write_t texel_writes_due[$];
	int unsigned  mismatches;
	int unsigned  cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// integer square root, bit by bit
	function automatic u64 sq_root64(input u64 v);
		u64 r;
		u64 b;
		r = 0;
		b = u64'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// cos(pi/2 * t) as sin(pi/2 * (1 - t)), odd series, Q16 result
	function automatic u64 quarter_cosine(input u64 t16);
		u64 u;
		u64 u2;
		u64 p;
		u = 64'd65536 - t16;
		u2 = (u * u) >> 16;
		p = u64'(CA9);
		p = u64'(CA7) - ((u2 * p) >> 16);
		p = u64'(CA5) - ((u2 * p) >> 16);
		p = u64'(CA3) - ((u2 * p) >> 16);
		p = u64'(CA1) - ((u2 * p) >> 16);
		p = (u * p) >> 30;
		return (p > 64'd65536) ? 64'd65536 : p;
	endfunction

	// c ^ (e / 256): 256th root by eight square roots, then square and multiply
	function automatic u64 falloff_power(input u64 c16, input int unsigned e8);
		u64 r;
		u64 acc;
		r = c16 << 14;
		acc = u64'(1) << 30;
		for (int i = 0; i < 8; i++) r = sq_root64(r << 30);
		while (e8 != 0) begin
			if (e8 & 1) acc = (acc * r) >> 30;
			r = (r * r) >> 30;
			e8 >>= 1;
		end
		return acc >> 14;
	endfunction

	function automatic u64 spot_intensity(input int unsigned c, input int unsigned rw,
			input int unsigned h);
		u64 s;
		u64 d16;
		u64 t16;
		if (h == 0) return 0;
		s = u64'(c + 1) * u64'(c + 1) + u64'(rw + 1) * u64'(rw + 1);
		d16 = sq_root64(s << 32) / h;
		if (d16 <= inner_rad) return 64'd65536;
		if (d16 >= 64'd65536) return 0;
		t16 = ((d16 - inner_rad) << 16) / (64'd65536 - inner_rad);
		return falloff_power(quarter_cosine(t16), falloff_exp);
	endfunction

	// queue the eight mirrored writes of one accepted sample
	task automatic push_texel_writes(input int unsigned c, input int unsigned rw,
			input bit typed, input int shade);
		int unsigned  sz;
		int unsigned  h;
		int unsigned  tx, ty, mx, my;
		u64           inten;
		texel_write_t w;
		int unsigned  xs[8];
		int unsigned  ys[8];
		sz = (tex_size > SIZE_CAP) ? SIZE_CAP : tex_size;
		h = (sz >= 4) ? (sz >> 1) - 1 : 0;
		inten = spot_intensity(c, rw, h);
		tx = c + h;
		ty = rw + h;
		mx = sz - tx - 1;
		my = sz - ty - 1;
		xs = '{tx, tx, mx, mx, ty, ty, my, my};
		ys = '{ty, my, ty, my, tx, mx, tx, mx};
		for (int k = 0; k < 8; k++) begin
			w.x = xs[k][COORD_W-1:0];
			w.y = ys[k][COORD_W-1:0];
			w.r = COLOR_W'((inten * light_r) >> 16);
			w.g = COLOR_W'((inten * light_g) >> 16);
			w.b = COLOR_W'((inten * light_b) >> 16);
			if (typed) begin
				w.r = COLOR_W'(shade);
				w.g = COLOR_W'(shade);
				w.b = COLOR_W'(shade);
			end
			w.lst = (k == 7);
			texel_writes_due.push_back(w);
		end
	endtask

	// write one register; the caller lowers cfg_we after its last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(val);
		case (idx)
			REG_TEXTURE_SIZE: tex_size    = val & 12'hFFF;
			REG_RADIUS:       inner_rad   = val & 16'hFFFF;
			REG_EXPONENT:     falloff_exp = val & 12'hFFF;
			REG_COLOR_RED:    light_r     = val & 8'hFF;
			REG_COLOR_GREEN:  light_g     = val & 8'hFF;
			REG_COLOR_BLUE:   light_b     = val & 8'hFF;
			default: ;
		endcase
	endtask

	task automatic load_light(input int unsigned sz, input int unsigned rad,
			input int unsigned ex, input int unsigned cr, input int unsigned cg,
			input int unsigned cb);
		write_reg(REG_TEXTURE_SIZE, sz);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_EXPONENT, ex);
		write_reg(REG_COLOR_RED, cr);
		write_reg(REG_COLOR_GREEN, cg);
		write_reg(REG_COLOR_BLUE, cb);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// hold the sample on the inputs until an edge with busy low takes it
	task automatic send_sample(input int unsigned c, input int unsigned rw,
			input bit typed, input int shade);
		@(negedge clk);
		start = 1'b1;
		col = IN_W'(c);
		row = IN_W'(rw);
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		push_texel_writes(c, rw, typed, shade);
	endtask

	// mostly back to back, sometimes short gaps, rarely long ones
	task automatic idle_after(input bit steady);
		int unsigned pick;
		int unsigned gap;
		pick = $urandom_range(0, 99);
		gap = 0;
		if (!steady) begin
			if (pick >= 90)
				gap = $urandom_range(20, 80);
			else if (pick >= 55)
				gap = $urandom_range(1, 4);
		end
		if (gap != 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (texel_writes_due.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// random samples, most inside the lit octant so the falloff math is reached
	task automatic random_samples(input int n);
		int unsigned sz;
		int unsigned h;
		int unsigned c, rw;
		bit          steady;
		steady = ($urandom_range(0, 3) == 0);
		sz = (tex_size > SIZE_CAP) ? SIZE_CAP : tex_size;
		h = (sz >= 4) ? (sz >> 1) - 1 : 0;
		if (h > 1023) h = 1023;
		for (int i = 0; i < n; i++) begin
			if (h > 0 && $urandom_range(0, 9) < 7) begin
				c = $urandom_range(0, h - 1);
				rw = $urandom_range(0, c);
			end else begin
				c = $urandom_range(0, 1023);
				rw = $urandom_range(0, 1023);
			end
			send_sample(c, rw, 1'b0, 0);
			if (i == n / 2 && n > 20) begin
				// hold off until the pipeline has emptied
				@(negedge clk);
				start = 1'b0;
				while (texel_writes_due.size() != 0) @(negedge clk);
			end else begin
				idle_after(steady);
			end
		end
	endtask

	// compare every beat with the oldest expected write
	always @(posedge clk) begin
		texel_write_t w;
		if (arst_n && valid) begin
			if (texel_writes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat x=%0d y=%0d", texel_x, texel_y);
			end else begin
				w = texel_writes_due.pop_front();
				if (texel_x !== w.x || texel_y !== w.y || red !== w.r ||
						green !== w.g || blue !== w.b || last !== w.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: exp x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b",
							w.x, w.y, w.r, w.g, w.b, w.lst,
							", got x=%0d y=%0d rgb=%0d/%0d/%0d last=%0b",
							texel_x, texel_y, red, green, blue, last);
				end
			end
		end
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	sample_row_t samples[] = '{
		'{0, 0, 1, 255},        // center: full brightness
		'{1022, 1022, 1, 0},    // far corner: dark
		'{1023, 0, 1, 0},       // column all ones
		'{0, 1023, 1, 0},       // row all ones
		'{127, 127, 1, 0},      // just past the edge
		'{126, 0, 0, 0},
		'{126, 126, 0, 0},
		'{89, 0, 0, 0},
		'{63, 0, 0, 0},
		'{64, 0, 0, 0},
		'{80, 20, 0, 0},
		'{60, 60, 0, 0},
		'{100, 10, 0, 0},
		'{45, 44, 0, 0},
		'{50, 90, 0, 0},        // below the diagonal
		'{3, 7, 0, 0},
		'{1, 1, 0, 0},
		'{512, 256, 0, 0},
		'{341, 682, 0, 0},
		'{110, 30, 0, 0}
	};

	// settings walked after the directed part: corners first, then random
	int unsigned lights[][6] = '{
		'{4, 0, 0, 255, 255, 255},
		'{2048, 65535, 4095, 0, 128, 255},
		'{0, 1000, 300, 255, 255, 255},
		'{3, 30000, 256, 255, 255, 255},
		'{255, 0, 4095, 200, 100, 50},
		'{4095, 20000, 1, 255, 255, 255},
		'{2048, 0, 256, 255, 255, 255},
		'{64, 40000, 0, 170, 85, 1},
		'{2046, 65000, 768, 255, 0, 255}
	};

	initial begin
		int unsigned rsz;
		start = 1'b0;
		col = '0;
		row = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		tex_size = 256;
		inner_rad = 32768;
		falloff_exp = 256;
		light_r = 255;
		light_g = 255;
		light_b = 255;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed samples on the reset settings
		foreach (samples[i]) begin
			send_sample(samples[i].c, samples[i].rw, samples[i].typed, samples[i].shade);
			idle_after(1'b0);
		end
		drain();

		foreach (lights[p]) begin
			load_light(lights[p][0], lights[p][1], lights[p][2],
				lights[p][3], lights[p][4], lights[p][5]);
			random_samples(PHASE_ITEMS);
			drain();
		end

		for (int p = 0; p < 3; p++) begin
			rsz = $urandom_range(2, 1024) * 2;
			load_light(rsz, $urandom_range(0, 65535),
				($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023) : $urandom_range(0, 4095),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			random_samples(PHASE_ITEMS);
			drain();
		end

		if (mismatches == 0 && texel_writes_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
